// File: rtl/core/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-n sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned MAX_WINDOW    = 16;
  localparam int unsigned BUF_DEPTH     = 64;
  localparam int unsigned PAYLOAD_BYTES = 20;
  localparam int unsigned BUF_AW        = $clog2(BUF_DEPTH);
  localparam int unsigned PAY_W         = 8 * PAYLOAD_BYTES;
  localparam int unsigned BIDX_W        = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned WIN_W         = 5;
  localparam int unsigned WIN_MAX       = (MAX_WINDOW < BUF_DEPTH) ? MAX_WINDOW : BUF_DEPTH;
  localparam int unsigned REM_W         = $clog2(MAX_WINDOW + 1);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

  typedef enum logic [1:0] {
    ACT_MSG  = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_TMO  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_e;

  typedef enum logic [1:0] {
    SEQ_HOLD = 2'd0,
    SEQ_SEND = 2'd1,
    SEQ_BASE = 2'd2,
    SEQ_INC  = 2'd3
  } seq_op_e;

  typedef enum logic [1:0] {
    REM_HOLD = 2'd0,
    REM_ONE  = 2'd1,
    REM_CNT  = 2'd2,
    REM_DEC  = 2'd3
  } rem_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MSG_SEND,
    ST_READ,
    ST_PINIT,
    ST_PCSUM,
    ST_POUT,
    ST_ACSUM,
    ST_ACHK,
    ST_ATMR,
    ST_EOUT
  } state_e;

  typedef struct packed {
    logic    in_load;
    logic    store_msg;
    logic    send_inc;
    logic    base_set;
    seq_op_e seq_op;
    rem_op_e rem_op;
    logic    res_set;
    timer_e  res_timer;
    logic    res_drop;
    logic    csum_pkt;
    logic    csum_ack;
    logic    csum_step;
    logic    out_pkt;
    logic    out_empty;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    ring_full;
    logic    send_ok;
    logic    base_eq_send;
    logic    none_out;
    logic    csum_done;
    logic    ack_good;
    logic    rem_last;
    logic    out_free;
  } sts_t;

endpackage

// File: rtl/core/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Event sequencer: steps the datapath through store, ack and resend work.
// ----------------------------------------------------------------------------
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.res_set = 1'b1;
        case (sts_i.action)
          ACT_MSG: begin
            if (sts_i.ring_full) begin
              cmd_o.res_drop = 1'b1;
              state_d        = ST_EOUT;
            end else begin
              cmd_o.store_msg = 1'b1;
              state_d         = ST_MSG_SEND;
            end
          end
          ACT_ACK: begin
            cmd_o.csum_ack = 1'b1;
            state_d        = ST_ACSUM;
          end
          ACT_TMO: begin
            cmd_o.res_timer = TMR_RESTART;
            if (sts_i.none_out) begin
              state_d = ST_EOUT;
            end else begin
              cmd_o.seq_op = SEQ_BASE;
              cmd_o.rem_op = REM_CNT;
              state_d      = ST_READ;
            end
          end
          default: begin
            state_d = ST_EOUT;
          end
        endcase
      end
      ST_MSG_SEND: begin
        cmd_o.res_set = 1'b1;
        if (sts_i.send_ok) begin
          cmd_o.res_timer = sts_i.base_eq_send ? TMR_START : TMR_NONE;
          cmd_o.seq_op    = SEQ_SEND;
          cmd_o.rem_op    = REM_ONE;
          cmd_o.send_inc  = 1'b1;
          state_d         = ST_READ;
        end else begin
          state_d = ST_EOUT;
        end
      end
      ST_READ: begin
        state_d = ST_PINIT;
      end
      ST_PINIT: begin
        cmd_o.csum_pkt = 1'b1;
        state_d        = ST_PCSUM;
      end
      ST_PCSUM: begin
        if (sts_i.csum_done) begin
          state_d = ST_POUT;
        end else begin
          cmd_o.csum_step = 1'b1;
        end
      end
      ST_POUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_pkt = 1'b1;
          if (sts_i.rem_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.seq_op    = SEQ_INC;
            cmd_o.rem_op    = REM_DEC;
            cmd_o.res_set   = 1'b1;
            cmd_o.res_timer = TMR_NONE;
            state_d         = ST_READ;
          end
        end
      end
      ST_ACSUM: begin
        if (sts_i.csum_done) begin
          state_d = ST_ACHK;
        end else begin
          cmd_o.csum_step = 1'b1;
        end
      end
      ST_ACHK: begin
        if (sts_i.ack_good) begin
          cmd_o.base_set = 1'b1;
          state_d        = ST_ATMR;
        end else begin
          cmd_o.res_set = 1'b1;
          state_d       = ST_EOUT;
        end
      end
      ST_ATMR: begin
        cmd_o.res_set   = 1'b1;
        cmd_o.res_timer = sts_i.base_eq_send ? TMR_STOP : TMR_RESTART;
        state_d         = ST_EOUT;
      end
      ST_EOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_empty = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp
// Datapath: window pointers, message ring, byte-serial checksum, output stage.
// ----------------------------------------------------------------------------
module gbn_dp
  import gbn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [WIN_W-1:0]   cfg_data_i,
  input  logic [255:0]       s_axis_tdata,
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [223:0]       m_axis_tdata,
  output logic [3:0]         m_axis_tuser,
  output logic               m_axis_tlast,
  input  cmd_t               cmd_i,
  output sts_t               sts_o
);

  logic [WIN_W-1:0]  win_q;
  logic [31:0]       base_q, nsend_q, nstore_q;
  action_e           act_q;
  logic [PAY_W-1:0]  pay_q;
  logic [31:0]       aseq_q, anum_q, achk_q;
  logic [PAY_W-1:0]  mem [BUF_DEPTH];
  logic [PAY_W-1:0]  rd_q;
  logic [31:0]       seq_q;
  logic [REM_W-1:0]  rem_q;
  timer_e            tmr_q;
  logic              drop_q;
  logic [31:0]       sum_q;
  logic [PAY_W-1:0]  cdata_q;
  logic [BIDX_W-1:0] bidx_q;
  logic              ovalid_q;
  logic [223:0]      odata_q;
  logic [3:0]        ouser_q;
  logic              olast_q;

  logic [WIN_W-1:0]  effw;
  logic [31:0]       outstanding, newbase;
  logic [REM_W-1:0]  cnt;

  always_comb begin
    effw = win_q;
    if (effw == '0) effw = WIN_W'(1);
    if (effw > WIN_W'(MAX_WINDOW)) effw = WIN_W'(MAX_WINDOW);
    if (effw > WIN_W'(WIN_MAX)) effw = WIN_W'(WIN_MAX);
    outstanding = nsend_q - base_q;
    newbase     = anum_q + 32'd1;
    cnt = (outstanding > 32'(MAX_WINDOW)) ? REM_W'(MAX_WINDOW) : outstanding[REM_W-1:0];
  end

  assign sts_o.action       = act_q;
  assign sts_o.ring_full    = (nstore_q - base_q) >= 32'(BUF_DEPTH);
  assign sts_o.send_ok      = (nsend_q != nstore_q) && (outstanding < 32'(effw));
  assign sts_o.base_eq_send = (base_q == nsend_q);
  assign sts_o.none_out     = (outstanding == '0);
  assign sts_o.csum_done    = (bidx_q == BIDX_W'(PAYLOAD_BYTES)) || (cdata_q[7:0] == 8'd0);
  assign sts_o.ack_good     = (sum_q == achk_q) && ((newbase - base_q) <= outstanding);
  assign sts_o.rem_last     = (rem_q == REM_W'(1));
  assign sts_o.out_free     = !ovalid_q || m_axis_tready;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WIN_RESET;
      base_q   <= 32'd1;
      nsend_q  <= 32'd1;
      nstore_q <= 32'd1;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) win_q <= cfg_data_i;
      if (cmd_i.store_msg) nstore_q <= nstore_q + 32'd1;
      if (cmd_i.send_inc) nsend_q <= nsend_q + 32'd1;
      if (cmd_i.base_set) base_q <= newbase;
      if (cmd_i.out_pkt || cmd_i.out_empty) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // message ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_msg) mem[nstore_q[BUF_AW-1:0]] <= pay_q;
    rd_q <= mem[seq_q[BUF_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      act_q  <= action_e'(s_axis_tuser);
      pay_q  <= s_axis_tdata[PAY_W-1:0];
      aseq_q <= s_axis_tdata[191:160];
      anum_q <= s_axis_tdata[223:192];
      achk_q <= s_axis_tdata[255:224];
    end
    case (cmd_i.seq_op)
      SEQ_SEND: seq_q <= nsend_q;
      SEQ_BASE: seq_q <= base_q;
      SEQ_INC:  seq_q <= seq_q + 32'd1;
      default:  seq_q <= seq_q;
    endcase
    case (cmd_i.rem_op)
      REM_ONE: rem_q <= REM_W'(1);
      REM_CNT: rem_q <= cnt;
      REM_DEC: rem_q <= rem_q - REM_W'(1);
      default: rem_q <= rem_q;
    endcase
    if (cmd_i.res_set) begin
      tmr_q  <= cmd_i.res_timer;
      drop_q <= cmd_i.res_drop;
    end
    // one payload byte per cycle, stops at the first zero byte or after the last byte
    if (cmd_i.csum_pkt) begin
      sum_q   <= seq_q;
      cdata_q <= rd_q;
      bidx_q  <= '0;
    end else if (cmd_i.csum_ack) begin
      sum_q   <= aseq_q + anum_q;
      cdata_q <= pay_q;
      bidx_q  <= '0;
    end else if (cmd_i.csum_step) begin
      sum_q   <= sum_q + {{24{cdata_q[7]}}, cdata_q[7:0]};
      cdata_q <= {8'd0, cdata_q[PAY_W-1:8]};
      bidx_q  <= bidx_q + BIDX_W'(1);
    end
    if (cmd_i.out_pkt) begin
      odata_q <= {rd_q, sum_q, seq_q};
      ouser_q <= {1'b0, tmr_q, 1'b1};
      olast_q <= (rem_q == REM_W'(1));
    end else if (cmd_i.out_empty) begin
      odata_q <= '0;
      ouser_q <= {drop_q, tmr_q, 1'b0};
      olast_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

endmodule

// File: rtl/core/go_back_n_sender.sv
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-back-n sender with a 64-entry message ring and a byte-serial checksum.
// ----------------------------------------------------------------------------
// One event is handled at a time. A message is dropped, only stored, or stored
// and sent; an ack is checksummed and checked; a timeout resends the
// outstanding packets, if any (up to 16 packets). The checksum unit adds one
// payload byte per cycle up to the first zero byte or the last byte, and packets
// are read through the single registered ring read port. A finished result
// waits in the output register while the next event is taken; a result that
// finds that register still held stalls until the receiver takes it.
// The ring has no reset pass; only stored entries are ever sent.
module go_back_n_sender
  import gbn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [WIN_W-1:0]   cfg_data_i,     // window_size
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // payload_low, payload_mid, payload_high, ack_seq_field, ack_number, ack_check
  input  logic [255:0]       s_axis_tdata,
  input  logic [1:0]         s_axis_tuser,   // action
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // out_seq, out_check, out_low, out_mid, out_high
  output logic [223:0]       m_axis_tdata,
  output logic [3:0]         m_axis_tuser,   // send_packet, timer_cmd, dropped
  output logic               m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gbn_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  gbn_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// File: tb/gbn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_checker
// Watches the config, input and output streams of the go-back-n sender,
// keeps its own copy of the window and message ring, and compares each
// output transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module gbn_checker
  import gbn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [WIN_W-1:0] cfg_data_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [255:0]     s_tdata_i,
  input  logic [1:0]       s_tuser_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [223:0]     m_tdata_i,
  input  logic [3:0]       m_tuser_i,
  input  logic             m_tlast_i,
  output int               fail_count_o,
  output int               pending_o,
  output logic [31:0]      base_o,
  output logic [31:0]      next_send_o
);

  typedef struct packed {
    logic        send_packet;
    logic [31:0] seq;
    logic [31:0] check;
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
    timer_e      timer;
    logic        dropped;
    logic        last;
  } tx_result_t;

  tx_result_t      results_q[$];
  logic [WIN_W-1:0] window_q;
  logic [31:0]     base_q, next_send_q, next_store_q;
  logic [159:0]    ring_q[BUF_DEPTH];
  int              fails;

  // sum of the start value (seq, or ack seq plus ack number) and signed payload bytes up to the first zero byte
  function automatic logic [31:0] pkt_checksum(logic [31:0] start, logic [159:0] pay);
    logic [31:0] sum;
    logic [7:0]  b;
    sum = start;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b = pay[8*i +: 8];
      if (b == 8'd0) break;
      sum = sum + {{24{b[7]}}, b};
    end
    return sum;
  endfunction

  function automatic logic [31:0] window_limit(logic [WIN_W-1:0] w);
    logic [31:0] lim;
    lim = 32'(w);
    if (lim == 0) lim = 1;
    if (lim > MAX_WINDOW) lim = MAX_WINDOW;
    if (lim > BUF_DEPTH) lim = BUF_DEPTH;
    return lim;
  endfunction

  function automatic tx_result_t no_packet(timer_e t, logic drop);
    tx_result_t r;
    r = '0;
    r.timer = t;
    r.dropped = drop;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic tx_result_t packet_of(logic [31:0] seq, timer_e t, logic lst);
    tx_result_t   r;
    logic [159:0] pay;
    pay = ring_q[seq % BUF_DEPTH];
    r = '0;
    r.send_packet = 1'b1;
    r.seq = seq;
    r.check = pkt_checksum(seq, pay);
    r.low = pay[63:0];
    r.mid = pay[127:64];
    r.high = pay[159:128];
    r.timer = t;
    r.last = lst;
    return r;
  endfunction

  // append one predicted result at the tail
  task automatic queue_result(tx_result_t r);
    results_q = {results_q, r};
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("field %s: expected %0h, actual %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  task automatic predict_event(action_e act, logic [255:0] d);
    logic [159:0] pay;
    logic [31:0]  sq, ak, ck, new_base, cnt;
    pay = d[159:0];
    sq = d[191:160];
    ak = d[223:192];
    ck = d[255:224];
    case (act)
      ACT_MSG: begin
        if (next_store_q - base_q >= BUF_DEPTH) begin
          queue_result(no_packet(TMR_NONE, 1'b1));
        end else begin
          ring_q[next_store_q % BUF_DEPTH] = pay;
          next_store_q++;
          if (next_send_q != next_store_q &&
              next_send_q - base_q < window_limit(window_q)) begin
            queue_result(packet_of(next_send_q,
                (base_q == next_send_q) ? TMR_START : TMR_NONE, 1'b1));
            next_send_q++;
          end else begin
            queue_result(no_packet(TMR_NONE, 1'b0));
          end
        end
      end
      ACT_ACK: begin
        new_base = ak + 1;
        if (pkt_checksum(sq + ak, pay) != ck ||
            new_base - base_q > next_send_q - base_q) begin
          queue_result(no_packet(TMR_NONE, 1'b0));
        end else begin
          base_q = new_base;
          queue_result(no_packet((base_q == next_send_q) ? TMR_STOP : TMR_RESTART,
                                 1'b0));
        end
      end
      ACT_TMO: begin
        cnt = next_send_q - base_q;
        if (cnt == 0) begin
          queue_result(no_packet(TMR_RESTART, 1'b0));
        end else begin
          if (cnt > MAX_WINDOW) cnt = MAX_WINDOW;
          for (int unsigned i = 0; i < cnt; i++)
            queue_result(packet_of(base_q + i, (i == 0) ? TMR_RESTART : TMR_NONE,
                                   i + 1 == cnt));
        end
      end
      default: queue_result(no_packet(TMR_NONE, 1'b0));
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tx_result_t exp_r;
    if (!rst_ni) begin
      window_q = WIN_RESET;
      base_q = 32'd1;
      next_send_q = 32'd1;
      next_store_q = 32'd1;
      fails = 0;
      results_q.delete();
      pending_o <= 0;
      base_o <= 32'd1;
      next_send_o <= 32'd1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) window_q = cfg_data_i;
      if (m_tvalid_i && m_tready_i) begin
        if (results_q.size() == 0) begin
          $error("output transfer with no result expected: tdata %0h", m_tdata_i);
          fails++;
        end else begin
          exp_r = results_q.pop_front();
          check_field("send_packet", exp_r.send_packet, m_tuser_i[0]);
          check_field("out_seq", exp_r.seq, m_tdata_i[31:0]);
          check_field("out_check", exp_r.check, m_tdata_i[63:32]);
          check_field("out_low", exp_r.low, m_tdata_i[127:64]);
          check_field("out_mid", exp_r.mid, m_tdata_i[191:128]);
          check_field("out_high", exp_r.high, m_tdata_i[223:192]);
          check_field("timer_cmd", exp_r.timer, m_tuser_i[2:1]);
          check_field("dropped", exp_r.dropped, m_tuser_i[3]);
          check_field("last", exp_r.last, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i) predict_event(action_e'(s_tuser_i), s_tdata_i);
      pending_o <= results_q.size();
      base_o <= base_q;
      next_send_o <= next_send_q;
    end
  end

  assign fail_count_o = fails;

endmodule

// File: tb/tb_go_back_n_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_back_n_sender
// Drives messages, acks and timeouts into the go-back-n sender under several
// window settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender;
  import gbn_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [WIN_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [255:0]     s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [223:0]     m_axis_tdata;
  logic [3:0]       m_axis_tuser;
  logic             m_axis_tlast;

  int          fail_count, pending;
  logic [31:0] base_now, next_send_now;
  int          send_idle_pct, recv_stall_pct;
  int          hold_len, hold_tag, hold_seen, hold_cnt;

  always #4 clk_i = ~clk_i;

  go_back_n_sender dut (.*);

  gbn_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .fail_count_o(fail_count), .pending_o(pending),
    .base_o(base_now), .next_send_o(next_send_now)
  );

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen = 0;
      hold_cnt = 0;
    end else begin
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_cnt = hold_len;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #80_000_000;
    $display("go_back_n_sender: mismatch");
    $finish;
  end

  function automatic logic [159:0] rand_payload();
    logic [159:0] p;
    for (int i = 0; i < 5; i++) p[32*i +: 32] = $urandom;
    if ($urandom_range(3) == 0) p[8*$urandom_range(19) +: 8] = 8'd0;
    return p;
  endfunction

  task automatic put_item(action_e act, logic [159:0] pay, logic [31:0] sq,
                          logic [31:0] ak, logic [31:0] ck);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {ck, ak, sq, pay};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_window(logic [WIN_W-1:0] w);
    drain();
    repeat (30) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic good_ack(logic [31:0] ak);
    logic [159:0] pay;
    logic [31:0]  sq;
    pay = rand_payload();
    pay[7:0] = 8'd0;
    sq = $urandom;
    put_item(ACT_ACK, pay, sq, ak, sq + ak);
  endtask

  task automatic rand_event(int msg_pct);
    logic [159:0] pay;
    logic [31:0]  sq, ak;
    int           r;
    r = $urandom_range(99);
    pay = rand_payload();
    sq = $urandom;
    ak = $urandom;
    if (r < msg_pct) begin
      put_item(ACT_MSG, pay, sq, ak, $urandom);
    end else if (r < msg_pct + 25) begin
      good_ack(base_now - 1 + $urandom_range(next_send_now - base_now));
    end else if (r < msg_pct + 33) begin
      // corrupt or far-off ack
      if ($urandom_range(1) == 0)
        put_item(ACT_ACK, {pay[159:8], 8'd0}, sq, base_now, sq + base_now + 1);
      else
        put_item(ACT_ACK, pay, sq, ak, $urandom);
    end else if (r < msg_pct + 45) begin
      put_item(ACT_TMO, pay, sq, ak, $urandom);
    end else begin
      put_item(ACT_NONE, pay, sq, ak, $urandom);
    end
  endtask

  initial begin
    logic [4:0] windows[6];
    windows = '{5'd8, 5'd0, 5'd31, 5'd1, 5'd16, 5'd5};
    send_idle_pct = 14;
    recv_stall_pct = 59;
    hold_len = 0;
    hold_tag = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: window 3, seqs 1..4 stored, 1..3 sent
    write_window(5'd3);
    put_item(ACT_TMO, '0, 32'd0, 32'd0, 32'd0);
    put_item(ACT_MSG, {160{1'b1}}, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    put_item(ACT_MSG, '0, 32'd0, 32'd0, 32'd0);
    put_item(ACT_MSG, {20{8'h80}}, 32'd0, 32'd0, 32'd0);
    put_item(ACT_MSG, {8'h00, {19{8'h7f}}}, 32'd0, 32'd0, 32'd0);
    put_item(ACT_TMO, '0, 32'd0, 32'd0, 32'd0);
    put_item(ACT_ACK, '0, 32'd5, 32'd1, 32'd7);                // corrupt
    put_item(ACT_ACK, '0, 32'd5, 32'd100, 32'd105);            // outside window
    put_item(ACT_ACK, 160'h7f80, 32'd5, 32'd1, 32'd5);         // signed bytes sum -1
    put_item(ACT_NONE, {160{1'b1}}, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    put_item(ACT_TMO, '0, 32'd0, 32'd0, 32'd0);
    put_item(ACT_ACK, {20{8'h01}}, 32'd9, 32'd3, 32'd32);      // all 20 bytes counted
    put_item(ACT_TMO, '0, 32'd0, 32'd0, 32'd0);
    put_item(ACT_MSG, rand_payload(), 32'd0, 32'd0, 32'd0);
    put_item(ACT_ACK, '0, 32'd0, 32'd4, 32'd4);                // stop timer

    for (int ph = 0; ph < 6; ph++) begin
      write_window(windows[ph]);
      if (ph == 2) begin
        send_idle_pct = 59;
        recv_stall_pct = 14;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // long receiver hold-off while the sender keeps offering
        hold_len = 1500;
        hold_tag++;
      end
      for (int n = 0; n < 40; n++) rand_event(50);
      if (ph == 1 || ph == 4) begin
        // fill the ring without acks until messages are dropped
        for (int n = 0; n < 70; n++) put_item(ACT_MSG, rand_payload(), $urandom, $urandom,
                                             $urandom);
        put_item(ACT_TMO, rand_payload(), $urandom, $urandom, $urandom);
        good_ack(next_send_now - 1);
        for (int n = 0; n < 10; n++) rand_event(40);
      end
      // pause until everything has come back, then acknowledge all
      drain();
      good_ack(next_send_now - 1);
      for (int n = 0; n < 10; n++) rand_event(20);
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("go_back_n_sender: match");
    end else begin
      $display("go_back_n_sender: mismatch");
    end
    $finish;
  end

endmodule
